// ===== sv/dmp_pkg.sv =====
// Shared types and constants for the delimited message parser.
package dmp_pkg;

  typedef enum logic [1:0] {
    PH_AWAIT_CHANNEL = 2'd0,
    PH_IN_CHANNEL    = 2'd1,
    PH_AWAIT_PAYLOAD = 2'd2,
    PH_IN_PAYLOAD    = 2'd3
  } phase_t;

  localparam logic [1:0] REG_CHANNEL_OPEN  = 2'd0;
  localparam logic [1:0] REG_CHANNEL_CLOSE = 2'd1;
  localparam logic [1:0] REG_PAYLOAD_OPEN  = 2'd2;
  localparam logic [1:0] REG_PAYLOAD_CLOSE = 2'd3;

  localparam logic [7:0] RST_CHANNEL_OPEN  = 8'd60;
  localparam logic [7:0] RST_CHANNEL_CLOSE = 8'd62;
  localparam logic [7:0] RST_PAYLOAD_OPEN  = 8'd40;
  localparam logic [7:0] RST_PAYLOAD_CLOSE = 8'd41;

  localparam logic [7:0] CHAR_MINUS = 8'h2D;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;
  localparam logic [7:0] CHAR_UC_A  = 8'h41;
  localparam logic [7:0] CHAR_UC_Z  = 8'h5A;
  localparam logic [7:0] CHAR_LC_A  = 8'h61;
  localparam logic [7:0] CHAR_LC_Z  = 8'h7A;

  localparam logic [30:0] MAG_LIMIT   = 31'h7FFF_FFFF;
  localparam logic [7:0]  COUNT_LIMIT = 8'hFF;

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= CHAR_ZERO) && (c <= CHAR_NINE);
  endfunction

  function automatic logic is_alnum(input logic [7:0] c);
    return is_digit(c) || ((c >= CHAR_UC_A) && (c <= CHAR_UC_Z)) ||
           ((c >= CHAR_LC_A) && (c <= CHAR_LC_Z));
  endfunction

endpackage

// ===== sv/delimited_message_parser.sv =====
// Delimited message parser: byte stream in, one result beat per completed message.
//
//  channel | direction | handshake               | payload
//  in      | input     | in_valid / in_stall     | rx_byte
//  out     | output    | out_valid / out_stall   | channel_text, channel_length,
//          |           |                         | payload_value, payload_length
//  cfg     | input     | cfg_write               | cfg_index, cfg_data
//
// One byte per cycle while in_stall is low. A byte is registered, then parsed by one pass
// of logic (a multiply by ten and saturate) that loads the result register when the byte completes a message.
// Reset clears the parser state and restores the default delimiters.
// Out stall only holds the input side when a parsed byte completes a message
// and the result register is still full.
module delimited_message_parser import dmp_pkg::*; #(
  parameter int MAX_CHANNEL_CHARS = 8
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [7:0]         rx_byte,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [63:0]        channel_text,
  output logic [3:0]         channel_length,
  output logic signed [31:0] payload_value,
  output logic [7:0]         payload_length,
  input  logic               cfg_write,
  input  logic [1:0]         cfg_index,
  input  logic [7:0]         cfg_data
);

  localparam logic [3:0] MAX_CHARS = 4'(MAX_CHANNEL_CHARS);

  logic [7:0] channel_open_char, channel_close_char;
  logic [7:0] payload_open_char, payload_close_char;

  logic       s1_valid;
  logic [7:0] s1_byte;
  logic       s1_go, s1_fire;

  phase_t      phase, phase_next;
  logic [63:0] name_store, name_store_next;
  logic [3:0]  name_count, name_count_next;
  logic        first_byte, first_byte_next;
  logic        minus_seen, minus_seen_next;
  logic [30:0] magnitude, magnitude_next;
  logic [7:0]  digit_count, digit_count_next;
  logic        emit;
  logic [34:0] mag_times_ten;
  logic [34:0] mag_sum;
  logic [7:0]  count_inc;
  logic signed [31:0] value_out;

  always_ff @(posedge clk) begin
    if (rst) begin
      channel_open_char  <= RST_CHANNEL_OPEN;
      channel_close_char <= RST_CHANNEL_CLOSE;
      payload_open_char  <= RST_PAYLOAD_OPEN;
      payload_close_char <= RST_PAYLOAD_CLOSE;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_CHANNEL_OPEN:  channel_open_char  <= cfg_data;
        REG_CHANNEL_CLOSE: channel_close_char <= cfg_data;
        REG_PAYLOAD_OPEN:  payload_open_char  <= cfg_data;
        REG_PAYLOAD_CLOSE: payload_close_char <= cfg_data;
        default: ;
      endcase
    end
  end

  // stage 1 parses unless its byte completes a message while the result register is full and stalled
  assign s1_go    = !emit || !out_valid || !out_stall;
  assign s1_fire  = s1_valid && s1_go;
  assign in_stall = s1_valid && !s1_go;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!in_stall) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      s1_byte <= rx_byte;
    end
  end

  assign mag_times_ten = {1'b0, magnitude, 3'b000} + {3'b000, magnitude, 1'b0};
  assign mag_sum       = mag_times_ten + {31'd0, s1_byte[3:0]};
  assign count_inc     = (digit_count == COUNT_LIMIT) ? digit_count : digit_count + 8'd1;
  assign value_out     = minus_seen ? -$signed({1'b0, magnitude}) : $signed({1'b0, magnitude});

  always_comb begin
    phase_next       = phase;
    name_store_next  = name_store;
    name_count_next  = name_count;
    first_byte_next  = first_byte;
    minus_seen_next  = minus_seen;
    magnitude_next   = magnitude;
    digit_count_next = digit_count;
    emit             = 1'b0;
    unique case (phase)
      PH_AWAIT_CHANNEL: begin
        if (s1_byte == channel_open_char) begin
          name_store_next = '0;
          name_count_next = '0;
          phase_next      = PH_IN_CHANNEL;
        end
      end
      PH_IN_CHANNEL: begin
        priority if (s1_byte == channel_close_char) begin
          phase_next = PH_AWAIT_PAYLOAD;
        end else if (s1_byte == channel_open_char) begin
          name_store_next = '0;
          name_count_next = '0;
        end else if (is_alnum(s1_byte) && name_count < MAX_CHARS) begin
          name_store_next[{name_count[2:0], 3'b000} +: 8] = s1_byte;
          name_count_next = name_count + 4'd1;
        end else begin
        end
      end
      PH_AWAIT_PAYLOAD: begin
        if (s1_byte == payload_open_char) begin
          magnitude_next   = '0;
          digit_count_next = '0;
          minus_seen_next  = 1'b0;
          first_byte_next  = 1'b1;
          phase_next       = PH_IN_PAYLOAD;
        end
      end
      PH_IN_PAYLOAD: begin
        first_byte_next = 1'b0;
        priority if (s1_byte == payload_close_char) begin
          emit       = 1'b1;
          phase_next = PH_AWAIT_CHANNEL;
        end else if (s1_byte == CHAR_MINUS && first_byte) begin
          minus_seen_next  = 1'b1;
          digit_count_next = count_inc;
        end else if (is_digit(s1_byte)) begin
          magnitude_next   = (mag_sum > {4'd0, MAG_LIMIT}) ? MAG_LIMIT : mag_sum[30:0];
          digit_count_next = count_inc;
        end else begin
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_AWAIT_CHANNEL;
      name_store  <= '0;
      name_count  <= '0;
      first_byte  <= 1'b0;
      minus_seen  <= 1'b0;
      magnitude   <= '0;
      digit_count <= '0;
    end else if (s1_fire) begin
      phase       <= phase_next;
      name_store  <= name_store_next;
      name_count  <= name_count_next;
      first_byte  <= first_byte_next;
      minus_seen  <= minus_seen_next;
      magnitude   <= magnitude_next;
      digit_count <= digit_count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_fire && emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire && emit) begin
      channel_text   <= name_store;
      channel_length <= name_count;
      payload_value  <= value_out;
      payload_length <= digit_count;
    end
  end

  a_reset_clears: assert property (@(posedge clk)
    rst |=> (phase == PH_AWAIT_CHANNEL) && !out_valid && !s1_valid)
    else $error("parser not idle after reset");

  a_stall_needs_byte: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> s1_valid && out_valid && out_stall)
    else $error("input stalled without a blocked message");

  a_name_bound: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> channel_length <= MAX_CHARS)
    else $error("channel length over limit");

  a_value_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> payload_value != 32'sh8000_0000)
    else $error("payload value out of range");

  a_sign_counted: assert property (@(posedge clk) disable iff (rst)
    (out_valid && payload_value < 0) |-> payload_length != 8'd0)
    else $error("negative value without counted sign");

endmodule
